[rtl/core/luma_contrast_stretch_top_macros.svh]
// assertion macros used by the checker file
`ifndef LUMA_CONTRAST_STRETCH_TOP_MACROS_SVH
`define LUMA_CONTRAST_STRETCH_TOP_MACROS_SVH

// clocked property, disabled while reset is asserted
`define LCS_ASSERT(label, clock, rst_n, prop, msg) \
	label: assert property (@(posedge clock) disable iff (!rst_n) prop) else $error(msg);

// condition that must hold at every clock edge out of reset
`define LCS_ASSERT_ALWAYS(label, clock, rst_n, cond, msg) \
	`LCS_ASSERT(label, clock, rst_n, (cond), msg)

`endif

[rtl/core/lcs_pkg.sv]
`timescale 1ns / 1ps

package lcs_pkg;

	// command codes carried in s_tuser
	localparam logic [1:0] CMD_MEASURE = 2'd0;
	localparam logic [1:0] CMD_ADJUST  = 2'd1;
	localparam logic [1:0] CMD_CLEAR   = 2'd2;

	localparam int PIX_W = 8;

	// quotient bits above the fraction: stretched luma saturates at 2^(F+10)
	localparam int QUOT_EXTRA = 11;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_LUMA,
		ST_UPDATE,
		ST_PREP,
		ST_SCALE,
		ST_LAUNCH,
		ST_DIVIDE,
		ST_DELTA,
		ST_EMIT
	} state_t;

endpackage

[rtl/core/lcs_div.sv]
`timescale 1ns / 1ps

// radix-2 restoring divider, one quotient bit per cycle, saturated result
module lcs_div #(
	parameter int FRAC = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [FRAC+15:0]               prod,     // dividend is prod << FRAC
	input  logic [FRAC+7:0]                divisor,
	output logic [FRAC+lcs_pkg::QUOT_EXTRA-1:0] quot,
	output logic                           done
);
	import lcs_pkg::*;

	localparam int LW = FRAC + 8;
	localparam int PW = LW + 8;
	localparam int QW = FRAC + QUOT_EXTRA;
	localparam int CW = $clog2(QW + 1);
	localparam logic [QW-1:0] LIMIT = {1'b1, {(QW-1){1'b0}}};

	logic [CW-1:0] cnt_q;
	logic          done_q;
	logic [LW-1:0] rem_q;
	logic [QW-1:0] low_q;
	logic [QW-1:0] quot_q;
	logic          ovf_q;

	logic [LW:0]   shifted;
	logic [LW+1:0] diff;
	logic          ge;
	logic [LW-1:0] prod_hi;

	assign prod_hi = LW'(prod[PW-1:QUOT_EXTRA]);
	assign shifted = {rem_q, low_q[QW-1]};
	assign diff    = {1'b0, shifted} - {2'b00, divisor};
	assign ge      = !diff[LW+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= (cnt_q == CW'(1));
			if (start) begin
				cnt_q <= CW'(QW);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= prod_hi;
			ovf_q  <= (prod_hi >= divisor);
			low_q  <= {prod[QUOT_EXTRA-1:0], {FRAC{1'b0}}};
			quot_q <= '0;
		end else if (cnt_q != '0) begin
			rem_q  <= ge ? diff[LW-1:0] : shifted[LW-1:0];
			low_q  <= {low_q[QW-2:0], 1'b0};
			quot_q <= {quot_q[QW-2:0], ge};
		end
	end

	assign quot = (ovf_q || (quot_q[QW-1] && (|quot_q[QW-2:0]))) ? LIMIT : quot_q;
	assign done = done_q;

endmodule

[rtl/core/luma_contrast_stretch_top.sv]
// luma contrast stretch, one pixel at a time
// measure: bit-serial luma, then a statistics update, then back to idle
// adjust: bit-serial luma, prep, scale, launch, the radix-2 divider, delta and emit,
//   emit waiting until the output register is free; flat range: straight to emit
// clear and unused commands stay in idle; a result waiting on m_tready does not block input
// reset (arst_n low, asynchronous): idle, no result pending, min all ones, max zero
`timescale 1ns / 1ps

module luma_contrast_stretch_top #(
	parameter int LUMA_FRACTION_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // red_in [7:0], green_in [15:8], blue_in [23:16]
	input  logic [1:0]  s_tuser,   // cmd [1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata    // red_out [7:0], green_out [15:8], blue_out [23:16]
);
	import lcs_pkg::*;

	localparam int F  = LUMA_FRACTION_BITS;
	localparam int LW = F + 8;            // luma, unsigned 8.F
	localparam int PW = LW + 8;           // luma difference times 255
	localparam int QW = F + QUOT_EXTRA;   // saturated stretched luma magnitude
	localparam int DW = F + 12;           // signed channel arithmetic

	// bt.601 weights rounded to nearest at F fraction bits
	localparam longint unsigned WR_FULL = ((64'd299 << F) + 64'd500) / 64'd1000;
	localparam longint unsigned WG_FULL = ((64'd587 << F) + 64'd500) / 64'd1000;
	localparam longint unsigned WB_FULL = ((64'd114 << F) + 64'd500) / 64'd1000;
	localparam logic [LW-1:0] WR = WR_FULL[LW-1:0];
	localparam logic [LW-1:0] WG = WG_FULL[LW-1:0];
	localparam logic [LW-1:0] WB = WB_FULL[LW-1:0];

	localparam logic [DW-1:0] HALF = {{(DW-F){1'b0}}, 1'b1, {(F-1){1'b0}}};

	// fsm
	state_t state_q, state_d;
	logic   accept;
	logic   out_free;
	logic   div_start;
	logic   load_out;

	// pixel and command held for the whole transaction
	logic [PIX_W-1:0] red_q, green_q, blue_q;
	logic [PIX_W-1:0] red_sh_q, green_sh_q, blue_sh_q;
	logic [2:0]       bit_cnt_q;
	logic             adjust_q;
	logic             pass_q;

	// statistics
	logic [LW-1:0] min_q, max_q;

	// adjust datapath
	logic [LW-1:0] luma_q;
	logic          neg_q;
	logic [LW-1:0] mag_q;
	logic [LW-1:0] range_q;
	logic [PW-1:0] prod_q;
	logic [DW-1:0] delta_q;

	// divider
	logic [QW-1:0] quot;
	logic          div_done;

	// output register
	logic        m_tvalid_q;
	logic [23:0] m_tdata_q;
	logic [23:0] result;

	logic [LW-1:0] luma_step;
	logic [DW-1:0] qx, yx;

	// rounding and clamping of one channel: c << F + delta, half up, 0..255
	function automatic logic [PIX_W-1:0] chan_finish(input logic [PIX_W-1:0] c,
			input logic [DW-1:0] d);
		logic [DW-1:0] vr;
		logic [PIX_W-1:0] r;
		vr = {{(DW-F-8){1'b0}}, c, HALF[F-1:0]} + d;
		if ($signed(vr) <= $signed(HALF)) begin
			r = '0;
		end else if (|vr[DW-1:F+8]) begin
			r = '1;
		end else begin
			r = vr[F+7:F];
		end
		return r;
	endfunction

	assign accept   = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;

	// next state and handshake
	always_comb begin
		state_d   = state_q;
		s_tready  = 1'b0;
		div_start = 1'b0;
		load_out  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					if (s_tuser == CMD_MEASURE) begin
						state_d = ST_LUMA;
					end else if (s_tuser == CMD_ADJUST) begin
						state_d = (min_q < max_q) ? ST_LUMA : ST_EMIT;
					end
				end
			end
			ST_LUMA: begin
				if (bit_cnt_q == 3'd0) begin
					state_d = adjust_q ? ST_PREP : ST_UPDATE;
				end
			end
			ST_UPDATE: state_d = ST_IDLE;
			ST_PREP:   state_d = ST_SCALE;
			ST_SCALE:  state_d = ST_LAUNCH;
			ST_LAUNCH: begin
				div_start = 1'b1;
				state_d   = ST_DIVIDE;
			end
			ST_DIVIDE: begin
				if (div_done) begin
					state_d = ST_DELTA;
				end
			end
			ST_DELTA: state_d = ST_EMIT;
			ST_EMIT: begin
				if (out_free) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// running luma statistics
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q <= '1;
			max_q <= '0;
		end else if (accept && s_tuser == CMD_CLEAR) begin
			min_q <= '1;
			max_q <= '0;
		end else if (state_q == ST_UPDATE) begin
			if (luma_q < min_q) begin
				min_q <= luma_q;
			end
			if (luma_q > max_q) begin
				max_q <= luma_q;
			end
		end
	end

	// one bit of each channel per cycle, msb first
	assign luma_step = {luma_q[LW-2:0], 1'b0}
		+ (red_sh_q[PIX_W-1] ? WR : '0)
		+ (green_sh_q[PIX_W-1] ? WG : '0)
		+ (blue_sh_q[PIX_W-1] ? WB : '0);

	assign qx = {1'b0, quot};
	assign yx = {{(DW-LW){1'b0}}, luma_q};

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					red_q      <= s_tdata[7:0];
					green_q    <= s_tdata[15:8];
					blue_q     <= s_tdata[23:16];
					red_sh_q   <= s_tdata[7:0];
					green_sh_q <= s_tdata[15:8];
					blue_sh_q  <= s_tdata[23:16];
					bit_cnt_q  <= 3'd7;
					luma_q     <= '0;
					adjust_q   <= (s_tuser == CMD_ADJUST);
					pass_q     <= !(min_q < max_q);
				end
			end
			ST_LUMA: begin
				luma_q     <= luma_step;
				red_sh_q   <= {red_sh_q[PIX_W-2:0], 1'b0};
				green_sh_q <= {green_sh_q[PIX_W-2:0], 1'b0};
				blue_sh_q  <= {blue_sh_q[PIX_W-2:0], 1'b0};
				bit_cnt_q  <= bit_cnt_q - 3'd1;
			end
			ST_PREP: begin
				// distance of the luma from the minimum, with its sign
				neg_q   <= (luma_q < min_q);
				mag_q   <= (luma_q < min_q) ? (min_q - luma_q) : (luma_q - min_q);
				range_q <= max_q - min_q;
			end
			ST_SCALE: begin
				// times 255 as a shift and a subtract
				prod_q <= {mag_q, 8'b0} - {8'b0, mag_q};
			end
			ST_DELTA: begin
				delta_q <= neg_q ? (DW'(0) - qx - yx) : (qx - yx);
			end
			default: ;
		endcase
	end

	lcs_div #(
		.FRAC(F)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.prod    (prod_q),
		.divisor (range_q),
		.quot    (quot),
		.done    (div_done)
	);

	// flat or unmeasured range passes the pixel through
	assign result = pass_q ? {blue_q, green_q, red_q}
		: {chan_finish(blue_q, delta_q), chan_finish(green_q, delta_q),
			chan_finish(red_q, delta_q)};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (load_out) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			m_tdata_q <= result;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

[rtl/core/lcs_checker.sv]
`timescale 1ns / 1ps
`include "luma_contrast_stretch_top_macros.svh"

module lcs_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [23:0] s_tdata,
	input logic [1:0]  s_tuser,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [23:0] m_tdata
);
	import lcs_pkg::*;

	logic [1:0] pend_q;
	logic       adj_in;
	logic       res_out;
	logic       busy_cmd;

	assign adj_in   = s_tvalid && s_tready && (s_tuser == CMD_ADJUST);
	assign res_out  = m_tvalid && m_tready;
	assign busy_cmd = s_tvalid && s_tready
		&& (s_tuser == CMD_MEASURE || s_tuser == CMD_ADJUST);

	// adjust transactions accepted but not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else begin
			pend_q <= pend_q + {1'b0, adj_in} - {1'b0, res_out};
		end
	end

	`LCS_ASSERT(a_out_hold, clk, arst_n, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "stalled result dropped or changed")
	`LCS_ASSERT_ALWAYS(a_no_invented, clk, arst_n, !m_tvalid || pend_q != 2'd0, "result without a pending adjust")
	`LCS_ASSERT_ALWAYS(a_depth, clk, arst_n, pend_q != 2'd3, "more than two adjust transactions outstanding")
	`LCS_ASSERT(a_busy_after, clk, arst_n, busy_cmd |=> !s_tready, "ready right after a measure or adjust")

endmodule

bind luma_contrast_stretch_top lcs_checker u_lcs_checker (.*);
